// ===== sv/skt_pkg.sv =====
// Shared types and constants for the sorted key table.
`default_nettype none

package skt_pkg;

  localparam int unsigned TypeW   = 4;
  localparam int unsigned ResW    = 16;
  localparam int unsigned KeyW    = TypeW + ResW;
  localparam int unsigned HandleW = 32;
  localparam int unsigned LengthW = 31;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PosW    = 8;

  typedef enum logic [StatusW-1:0] {
    ST_REPLACED = 2'd0,
    ST_INSERTED = 2'd1,
    ST_FULL     = 2'd2
  } skt_status_e;

  typedef struct packed {
    logic [KeyW-1:0]    key;
    logic [HandleW-1:0] handle;
    logic [LengthW-1:0] length;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic        idle;
    logic        rd_mid;
    logic        cmp;
    logic        shift_init;
    logic        shift_rd;
    logic        write_new;
    logic        count_inc;
    logic        finish;
    skt_status_e status;
  } skt_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic req_valid;
    logic search_open;
    logic found;
    logic full;
    logic shift_need;
    logic shift_last;
    logic out_free;
  } skt_sts_t;

endpackage

`default_nettype wire

// ===== sv/skt_if.sv =====
// Request and response channel interfaces for the sorted key table.
`default_nettype none

interface skt_req_if import skt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TypeW-1:0]   type_id;
  logic [ResW-1:0]    res_id;
  logic [HandleW-1:0] data_handle;
  logic [LengthW-1:0] data_length;

  modport source (output valid, type_id, res_id, data_handle, data_length, input ready);
  modport sink (input valid, type_id, res_id, data_handle, data_length, output ready);
endinterface

interface skt_rsp_if import skt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [PosW-1:0]    position;

  modport source (output valid, status, position, input ready);
  modport sink (input valid, status, position, output ready);
endinterface

`default_nettype wire

// ===== sv/sorted_key_table_upsert.sv =====
// Top level of the sorted key table with insert-or-replace.
//
//   channel  dir  payload                                      handshake
//   req_i    in   type_id, res_id, data_handle, data_length    valid/ready
//   rsp_o    out  status, position                             valid/ready
//
// One request at a time. A binary search over the n stored entries reads each
// probe through the single registered memory read port, then compares it. An
// insert at position p then moves n-p entries at one per cycle, then drains
// the last shift write, writes the new entry and responds.
// Reset empties the table by clearing the entry count; no memory sweep.
// A stalled response holds the next request in its final state until taken.
`default_nettype none

module sorted_key_table_upsert import skt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  skt_req_if.sink   req_i,
  skt_rsp_if.source rsp_o
);

  skt_cmd_t cmd;
  skt_sts_t sts;

  skt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  skt_datapath #(
    .TableDepth (TABLE_DEPTH)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule

`default_nettype wire

// ===== sv/skt_datapath.sv =====
// Table memory, binary search registers, shift pipeline and response register.
`default_nettype none

module skt_datapath import skt_pkg::*; #(
  parameter int unsigned TableDepth = 256,
  localparam int unsigned AW = (TableDepth > 1) ? $clog2(TableDepth) : 1,
  localparam int unsigned CW = $clog2(TableDepth + 1)
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  skt_req_if.sink       req_i,
  skt_rsp_if.source     rsp_o,
  input  wire skt_cmd_t cmd_i,
  output skt_sts_t      sts_o
);

  entry_t mem [TableDepth];

  logic [KeyW-1:0]    key_q;
  logic [HandleW-1:0] handle_q;
  logic [LengthW-1:0] length_q;
  logic [CW-1:0]      count_q;
  logic [CW-1:0]      lo_q, hi_q;
  logic               found_q;
  logic [AW-1:0]      ptr_q;
  logic               pend_q;
  logic [AW-1:0]      pend_addr_q;
  entry_t             rd_q;
  logic               out_valid_q;
  logic [StatusW-1:0] out_status_q;
  logic [PosW-1:0]    out_pos_q;

  logic [CW:0]    mid_sum;
  logic [AW-1:0]  mid;
  logic           load;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  entry_t         wr_data;
  logic           key_less, key_eq;

  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid      = mid_sum[AW:1];
  assign load     = cmd_i.idle && req_i.valid;
  assign key_less = rd_q.key < key_q;
  assign key_eq   = rd_q.key == key_q;

  always_comb begin
    rd_en   = cmd_i.rd_mid || cmd_i.shift_rd;
    rd_addr = cmd_i.rd_mid ? mid : ptr_q;
    // A pending shift write always wins; the controller never overlaps it with a new write.
    wr_en   = pend_q || cmd_i.write_new;
    wr_addr = pend_q ? pend_addr_q : lo_q[AW-1:0];
    wr_data = pend_q ? rd_q : entry_t'{key: key_q, handle: handle_q, length: length_q};
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      key_q    <= {req_i.type_id, req_i.res_id};
      handle_q <= req_i.data_handle;
      length_q <= req_i.data_length;
      lo_q     <= '0;
      hi_q     <= count_q;
    end else if (cmd_i.cmp) begin
      if (key_eq) begin
        lo_q <= CW'(mid);
        hi_q <= CW'(mid);
      end else if (key_less) begin
        lo_q <= CW'(mid) + CW'(1);
      end else begin
        hi_q <= CW'(mid);
      end
    end
    if (cmd_i.shift_init) begin
      ptr_q <= AW'(count_q - CW'(1));
    end else if (cmd_i.shift_rd) begin
      ptr_q <= ptr_q - AW'(1);
    end
    pend_addr_q <= ptr_q + AW'(1);
    if (cmd_i.finish) begin
      out_status_q <= cmd_i.status;
      out_pos_q    <= (cmd_i.status == ST_FULL) ? '0 : PosW'(lo_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      found_q     <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.count_inc) begin
        count_q <= count_q + CW'(1);
      end
      if (load) begin
        found_q <= 1'b0;
      end else if (cmd_i.cmp && key_eq) begin
        found_q <= 1'b1;
      end
      // Each shift read becomes a write one place higher on the next cycle.
      pend_q <= cmd_i.shift_rd;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign req_i.ready    = cmd_i.idle;
  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.status   = out_status_q;
  assign rsp_o.position = out_pos_q;

  always_comb begin
    sts_o.req_valid   = req_i.valid;
    sts_o.search_open = lo_q < hi_q;
    sts_o.found       = found_q;
    sts_o.full        = count_q == CW'(TableDepth);
    sts_o.shift_need  = count_q > lo_q;
    sts_o.shift_last  = ptr_q == lo_q[AW-1:0];
    sts_o.out_free    = !out_valid_q || rsp_o.ready;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TableDepth))
    else $error("entry count above table depth");

  a_wr_conflict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pend_q && cmd_i.write_new))
    else $error("shift write collides with new entry write");

  a_rsp_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (!out_valid_q || rsp_o.ready))
    else $error("response overwritten before it was taken");

  a_shift_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift_rd |-> (count_q < CW'(TableDepth)))
    else $error("shift started on a full table");

endmodule

`default_nettype wire

// ===== sv/skt_ctrl.sv =====
// Sequencer for search, shift, write and response of one upsert request.
`default_nettype none

module skt_ctrl import skt_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire skt_sts_t sts_i,
  output skt_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_DECIDE,
    S_SHIFT,
    S_DRAIN,
    S_WRITE,
    S_FINISH
  } state_e;

  state_e      state_q;
  skt_status_e st_q;

  always_comb begin
    cmd_o        = '0;
    cmd_o.status = st_q;
    unique case (state_q)
      S_IDLE:     cmd_o.idle = 1'b1;
      S_SRCH_RD:  cmd_o.rd_mid = sts_i.search_open;
      S_SRCH_CMP: cmd_o.cmp = 1'b1;
      S_DECIDE:   cmd_o.shift_init = !sts_i.found && !sts_i.full && sts_i.shift_need;
      S_SHIFT:    cmd_o.shift_rd = 1'b1;
      S_DRAIN:    cmd_o.idle = 1'b0;
      S_WRITE: begin
        cmd_o.write_new = 1'b1;
        cmd_o.count_inc = !sts_i.found;
      end
      S_FINISH:   cmd_o.finish = sts_i.out_free;
      default:    cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= ST_REPLACED;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (sts_i.req_valid) state_q <= S_SRCH_RD;
        end
        S_SRCH_RD: begin
          state_q <= sts_i.search_open ? S_SRCH_CMP : S_DECIDE;
        end
        S_SRCH_CMP: state_q <= S_SRCH_RD;
        S_DECIDE: begin
          if (sts_i.found) begin
            st_q    <= ST_REPLACED;
            state_q <= S_WRITE;
          end else if (sts_i.full) begin
            st_q    <= ST_FULL;
            state_q <= S_FINISH;
          end else begin
            st_q    <= ST_INSERTED;
            state_q <= sts_i.shift_need ? S_SHIFT : S_WRITE;
          end
        end
        S_SHIFT: begin
          if (sts_i.shift_last) state_q <= S_DRAIN;
        end
        // Let the last shift write land before the new entry takes the port.
        S_DRAIN:  state_q <= S_WRITE;
        S_WRITE:  state_q <= S_FINISH;
        S_FINISH: begin
          if (sts_i.out_free) state_q <= S_IDLE;
        end
        default:  state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
